@@ hw/rtl/cbc_pkg.sv @@
// cbc_pkg: shared types, codes and helpers of the cartridge bank controller
// no dependencies; imported by the interfaces, the bank registers, the top and the bench
`timescale 1ns / 1ps

package cbc_pkg;

	// default geometry of the banked cartridge RAM
	localparam int RAM_BANKS_DEF  = 4;
	localparam int BANK_BYTES_DEF = 8192;

	// window of the banked RAM inside one bank region
	localparam int RAM_OFF_BITS = 13;
	localparam int RAM_WIN_BYTES = 1 << RAM_OFF_BITS;

	localparam logic [7:0] OPEN_BUS   = 8'hFF;
	localparam logic [3:0] RAM_KEY    = 4'hA;

	// access kind
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} opcode_t;

	// address region, bus address bits 15..13
	typedef enum logic [2:0] {
		RGN_RAM_ENABLE = 3'd0,
		RGN_ROM_LOW    = 3'd1,
		RGN_BANK_HIGH  = 3'd2,
		RGN_MODE       = 3'd3,
		RGN_RAM_WINDOW = 3'd5
	} region_t;

	// mapper state seen by the response channel
	typedef struct packed {
		logic [6:0] rom_bank;
		logic [1:0] ram_bank;
		logic       ram_en;
		logic       mode;
	} bank_state_t;

	// ram access requested by the decoder for the accepted request
	typedef struct packed {
		logic wr;
		logic rd_hit;
	} ram_ctl_t;

	// rom bank values with zero low bits step to the next bank
	function automatic logic [6:0] bump_rom(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (v[4:0] == 5'd0) begin
			r[0] = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/cbc_if.sv @@
// cbc_req_if / cbc_rsp_if: valid-ready channels of the bank controller
// depends on cbc_pkg
`timescale 1ns / 1ps

interface cbc_req_if import cbc_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] bus_address;
	logic [7:0]  write_data;

	modport source (output valid, output opcode, output bus_address, output write_data,
		input ready);
	modport sink (input valid, input opcode, input bus_address, input write_data,
		output ready);
endinterface

interface cbc_rsp_if import cbc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [6:0] rom_bank;
	logic [1:0] ram_bank;
	logic       ram_enabled;
	logic       bank_mode;

	modport source (output valid, output read_data, output rom_bank, output ram_bank,
		output ram_enabled, output bank_mode, input ready);
	modport sink (input valid, input read_data, input rom_bank, input ram_bank,
		input ram_enabled, input bank_mode, output ready);
endinterface

@@ hw/rtl/cbc_ram.sv @@
// cbc_ram: generic single-port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps

module cbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or registered read, one port
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ hw/rtl/cbc_bank_regs.sv @@
// cbc_bank_regs: write decoder and bank/mode/enable registers
// depends on cbc_pkg
`timescale 1ns / 1ps

module cbc_bank_regs import cbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic        opcode,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	input  logic        ram_present,
	output bank_state_t state,
	output ram_ctl_t    ram_ctl
);

	logic [6:0] rom_bank_q;
	logic [1:0] ram_bank_q;
	logic       ram_en_q;
	logic       mode_q;
	region_t    rgn;
	logic       in_window;

	assign rgn       = region_t'(bus_address[15:13]);
	assign in_window = (bus_address[15:13] == RGN_RAM_WINDOW);

	// register updates on accepted writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= 7'd1;
			ram_bank_q <= 2'd0;
			ram_en_q   <= 1'b0;
			mode_q     <= 1'b0;
		end else if (acc && opcode == OP_WRITE) begin
			case (rgn)
				RGN_RAM_ENABLE: ram_en_q <= (write_data[3:0] == RAM_KEY) && ram_present;
				RGN_ROM_LOW:    rom_bank_q <= bump_rom({rom_bank_q[6:5], write_data[4:0]});
				RGN_BANK_HIGH: begin
					if (mode_q) begin
						ram_bank_q <= write_data[1:0];
					end else begin
						rom_bank_q <= bump_rom({write_data[1:0], rom_bank_q[4:0]});
					end
				end
				RGN_MODE:       mode_q <= write_data[0];
				default: ;
			endcase
		end
	end

	// ram access for the accepted request
	always_comb begin
		ram_ctl.wr     = acc && opcode == OP_WRITE && in_window && ram_en_q;
		ram_ctl.rd_hit = acc && opcode == OP_READ && in_window && ram_en_q && ram_present;
	end

	assign state = '{rom_bank: rom_bank_q, ram_bank: ram_bank_q, ram_en: ram_en_q,
		mode: mode_q};

endmodule

@@ hw/rtl/cartridge_bank_controller_top.sv @@
// cartridge_bank_controller_top: bank mapper with banked cartridge ram
// depends on cbc_pkg, cbc_if, cbc_ram, cbc_bank_regs
`timescale 1ns / 1ps
//
// channel  dir  handshake     payload
// req      in   valid/ready   opcode, bus_address, write_data
// rsp      out  valid/ready   read_data, rom_bank, ram_bank, ram_enabled, bank_mode
// cfg      in   cfg_we        cfg_wdata (ram_bank_count)
//
// one request per cycle while responses are taken; each response is registered in the response stage
// and shows in the cycle after its request, read data from the registered read port of the cartridge ram.
// reset returns the bank registers to their defaults and clears the response stage; ram contents are
// undefined until written, no clearing pass.
// a held response stalls the request side until it is taken.

module cartridge_bank_controller_top import cbc_pkg::*; #(
	parameter int RAM_BANKS  = RAM_BANKS_DEF,
	parameter int BANK_BYTES = BANK_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	cbc_req_if.sink    req,
	cbc_rsp_if.source  rsp
);

	localparam int DEPTH     = RAM_BANKS * BANK_BYTES;
	localparam int AW        = $clog2(DEPTH);
	localparam int OFF_STEPS = (RAM_WIN_BYTES + BANK_BYTES - 1) / BANK_BYTES - 1;
	localparam int BANK_STEPS = 3;

	logic [2:0]  bank_count_q;
	logic        acc;
	bank_state_t state;
	ram_ctl_t    ram_ctl;
	logic        out_valid_q;
	logic        rd_hit_s1;
	logic [7:0]  ram_rdata;
	logic [13:0] off_m;
	logic [2:0]  bank_m;
	logic [AW-1:0] ram_addr;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q <= 3'd0;
		end else if (cfg_we) begin
			bank_count_q <= cfg_wdata;
		end
	end

	assign req.ready = !out_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	cbc_bank_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.opcode      (req.opcode),
		.bus_address (req.bus_address),
		.write_data  (req.write_data),
		.ram_present (bank_count_q != 3'd0),
		.state       (state),
		.ram_ctl     (ram_ctl)
	);

	// fold offset and bank into the store
	always_comb begin
		off_m  = {1'b0, req.bus_address[RAM_OFF_BITS-1:0]};
		bank_m = {1'b0, state.ram_bank};
		for (int i = 0; i < OFF_STEPS; i++) begin
			if (off_m >= 14'(BANK_BYTES)) begin
				off_m = off_m - 14'(BANK_BYTES);
			end
		end
		for (int i = 0; i < BANK_STEPS; i++) begin
			if (bank_m >= 3'(RAM_BANKS)) begin
				bank_m = bank_m - 3'(RAM_BANKS);
			end
		end
		ram_addr = AW'(32'(bank_m) * BANK_BYTES) + AW'(off_m);
	end

	cbc_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_ctl.wr || ram_ctl.rd_hit),
		.we    (ram_ctl.wr),
		.addr  (ram_addr),
		.wdata (req.write_data),
		.rdata (ram_rdata)
	);

	// response stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_hit_s1   <= 1'b0;
		end else if (req.ready) begin
			out_valid_q <= req.valid;
			rd_hit_s1   <= ram_ctl.rd_hit;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = rd_hit_s1 ? ram_rdata : OPEN_BUS;
	assign rsp.rom_bank    = state.rom_bank;
	assign rsp.ram_bank    = state.ram_bank;
	assign rsp.ram_enabled = state.ram_en;
	assign rsp.bank_mode   = state.mode;

	// rom bank never lands on a bank with zero low bits
	a_rom_bump: assert property (@(posedge clk) disable iff (!arst_n)
		state.rom_bank[4:0] != 5'd0)
		else $error("rom bank with zero low bits");

	// enable is refused while no ram is present
	a_ram_absent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.opcode == OP_WRITE && req.bus_address[15:13] == RGN_RAM_ENABLE
		&& bank_count_q == 3'd0 |=> !state.ram_en)
		else $error("ram enabled without ram present");

	// an accepted request always yields a response next cycle
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp.valid)
		else $error("accepted request without response");

	// ram data is only shown for a read that hit the window; checked here for writes
	a_hit_read: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.opcode == OP_WRITE |=> rsp.read_data == OPEN_BUS)
		else $error("write request returned ram data");

endmodule

@@ dv/tb_cartridge_bank_controller_top.sv @@
// tb_cartridge_bank_controller_top: self-checking bench for the cartridge bank mapper
// predicts bank registers and banked ram contents for every request and checks each response
// depends on cbc_pkg, cbc_if and the cartridge_bank_controller_top rtl
`timescale 1ns / 1ps

module tb_cartridge_bank_controller_top;
	import cbc_pkg::*;

	localparam int RAM_BYTES = RAM_BANKS_DEF * BANK_BYTES_DEF;

	typedef struct packed {
		opcode_t     op;
		logic [15:0] addr;
		logic [7:0]  data;
	} access_t;

	typedef struct packed {
		logic [7:0]  read_data;
		bank_state_t bank;
	} map_result_t;

	localparam bank_state_t BANK_RESET = '{rom_bank: 7'd1, ram_bank: 2'd0, ram_en: 1'b0,
		mode: 1'b0};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	cbc_req_if req_bus ();
	cbc_rsp_if rsp_bus ();

	cartridge_bank_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	// requests waiting for the driver and responses waiting to arrive
	access_t     pending_reqs[$];
	map_result_t expected_rsps[$];

	// mapper state as seen at request acceptance
	bank_state_t pred_bank  = BANK_RESET;
	logic [2:0]  pred_count = '0;
	bit [7:0]    ram_image[int];

	// mapper state as seen while requests are generated
	bank_state_t gen_bank  = BANK_RESET;
	logic [2:0]  gen_count = '0;
	bit          gen_written[0:RAM_BYTES-1];

	access_t cur_req = '{op: OP_WRITE, addr: '0, data: '0};
	bit      req_busy  = 1'b0;
	bit      req_taken = 1'b0;
	bit      rsp_taken = 1'b0;
	bit      idle_on   = 1'b1;
	int      req_gap   = 0;
	int      rsp_wait  = 0;

	int fail_count   = 0;
	int active_items = 0;
	int rsp_checked  = 0;
	int ram_hits     = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// rom bank values with zero low five bits move on to the next bank
	function automatic logic [6:0] skip_zero_bank(input logic [6:0] v);
		if (v == 7'h00 || v == 7'h20 || v == 7'h40 || v == 7'h60) begin
			return v + 7'd1;
		end
		return v;
	endfunction

	function automatic int ram_slot(input logic [1:0] bank, input logic [15:0] addr);
		return (int'(bank) % RAM_BANKS_DEF) * BANK_BYTES_DEF
			+ (int'(addr[RAM_OFF_BITS-1:0]) % BANK_BYTES_DEF);
	endfunction

	// register update caused by one request
	function automatic bank_state_t next_bank(input bank_state_t s, input access_t a,
		input logic [2:0] count);
		bank_state_t n;
		n = s;
		if (a.op == OP_WRITE) begin
			case (region_t'(a.addr[15:13]))
				RGN_RAM_ENABLE: begin
					n.ram_en = (a.data[3:0] == RAM_KEY) && (count != 3'd0);
				end
				RGN_ROM_LOW: begin
					n.rom_bank = skip_zero_bank({s.rom_bank[6:5], a.data[4:0]});
				end
				RGN_BANK_HIGH: begin
					if (s.mode) begin
						n.ram_bank = a.data[1:0];
					end else begin
						n.rom_bank = skip_zero_bank({a.data[1:0], s.rom_bank[4:0]});
					end
				end
				RGN_MODE: begin
					n.mode = a.data[0];
				end
				default: ;
			endcase
		end
		return n;
	endfunction

	// expected response of one accepted request, updates the predicted ram and registers
	function automatic map_result_t predict_access(input access_t a);
		map_result_t r;
		int          slot;
		bit          in_window;
		slot      = ram_slot(pred_bank.ram_bank, a.addr);
		in_window = (region_t'(a.addr[15:13]) == RGN_RAM_WINDOW);
		r.read_data = OPEN_BUS;
		if (a.op == OP_WRITE) begin
			if (in_window && pred_bank.ram_en) begin
				ram_image[slot] = a.data;
			end
		end else if (in_window && pred_bank.ram_en && pred_count != 3'd0) begin
			r.read_data = ram_image[slot];
			ram_hits++;
		end
		pred_bank = next_bank(pred_bank, a, pred_count);
		r.bank    = pred_bank;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// queue one request; a ram read that would hit a never written byte becomes a write
	task automatic queue_access(input opcode_t op, input logic [15:0] addr,
		input logic [7:0] data);
		access_t a;
		int      slot;
		bit      in_window;
		slot      = ram_slot(gen_bank.ram_bank, addr);
		in_window = (region_t'(addr[15:13]) == RGN_RAM_WINDOW);
		if (op == OP_READ && in_window && gen_bank.ram_en && gen_count != 3'd0
			&& !gen_written[slot]) begin
			op = OP_WRITE;
		end
		if (op == OP_WRITE && in_window && gen_bank.ram_en) begin
			gen_written[slot] = 1'b1;
		end
		active_items++;
		a        = '{op: op, addr: addr, data: data};
		gen_bank = next_bank(gen_bank, a, gen_count);
		pending_reqs.push_back(a);
	endtask

	// wait until every queued request has been answered
	task automatic wait_quiet();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || req_busy || expected_rsps.size() != 0);
	endtask

	task automatic set_bank_count(input logic [2:0] v);
		wait_quiet();
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		gen_count = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// monitor: request acceptance, config writes and response checking
	always @(posedge clk) begin
		req_taken = 1'b0;
		rsp_taken = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				pred_count = cfg_wdata;
			end
			req_taken = req_bus.valid && req_bus.ready;
			if (req_taken) begin
				expected_rsps.push_back(predict_access('{op: opcode_t'(req_bus.opcode),
					addr: req_bus.bus_address, data: req_bus.write_data}));
			end
			rsp_taken = rsp_bus.valid && rsp_bus.ready;
			if (rsp_taken) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t response with no request outstanding: read_data 0x%0h",
						$time, rsp_bus.read_data);
					fail_count++;
				end else begin
					map_result_t want;
					want = expected_rsps.pop_front();
					check_field("read_data", want.read_data, rsp_bus.read_data);
					check_field("rom_bank", 8'(want.bank.rom_bank), 8'(rsp_bus.rom_bank));
					check_field("ram_bank", 8'(want.bank.ram_bank), 8'(rsp_bus.ram_bank));
					check_field("ram_enabled", 8'(want.bank.ram_en), 8'(rsp_bus.ram_enabled));
					check_field("bank_mode", 8'(want.bank.mode), 8'(rsp_bus.bank_mode));
					rsp_checked++;
				end
			end
		end
	end

	// request driver with a random gap after each request while idle_on is set
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_busy && req_taken) begin
				req_busy = 1'b0;
			end
			if (!req_busy) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (pending_reqs.size() > 0) begin
					cur_req  = pending_reqs.pop_front();
					req_busy = 1'b1;
					req_gap  = idle_on ? $urandom_range(0, 7) : 0;
				end
			end
		end
		req_bus.valid       <= req_busy;
		req_bus.opcode      <= cur_req.op;
		req_bus.bus_address <= cur_req.addr;
		req_bus.write_data  <= cur_req.data;
	end

	// response side inserts a random stall after each taken response while idle_on is set
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken) begin
				rsp_wait = idle_on ? $urandom_range(0, 7) : 0;
			end
			if (rsp_wait > 0) begin
				rsp_wait--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end else begin
			rsp_bus.ready <= 1'b0;
		end
	end

	// stimulus
	initial begin
		int          bank_counts[6];
		int          phase_goal;
		int          pick;
		opcode_t     op;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [12:0] off;

		bank_counts = '{4, 0, 1, 3, 4, 2};
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_bus.valid       = 1'b0;
		req_bus.opcode      = OP_WRITE;
		req_bus.bus_address = '0;
		req_bus.write_data  = '0;
		rsp_bus.ready       = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: register extremes, bank bump, ram window edges, ignored regions
		set_bank_count(3'd4);
		queue_access(OP_READ,  16'hA000, 8'h00);
		queue_access(OP_WRITE, 16'h0000, 8'h0A);
		queue_access(OP_WRITE, 16'hA000, 8'h00);
		queue_access(OP_WRITE, 16'hBFFF, 8'hFF);
		queue_access(OP_READ,  16'hA000, 8'hFF);
		queue_access(OP_READ,  16'hBFFF, 8'h00);
		queue_access(OP_WRITE, 16'h2000, 8'h00);
		queue_access(OP_WRITE, 16'h3FFF, 8'h1F);
		queue_access(OP_WRITE, 16'h4000, 8'h03);
		queue_access(OP_WRITE, 16'h2000, 8'hE0);
		queue_access(OP_WRITE, 16'h6000, 8'h01);
		queue_access(OP_WRITE, 16'h5FFF, 8'h03);
		queue_access(OP_WRITE, 16'hA123, 8'h5A);
		queue_access(OP_READ,  16'hA123, 8'h00);
		queue_access(OP_READ,  16'h0123, 8'h00);
		queue_access(OP_READ,  16'hC000, 8'h00);
		queue_access(OP_WRITE, 16'h7FFF, 8'hFE);
		queue_access(OP_WRITE, 16'h8000, 8'h77);
		queue_access(OP_WRITE, 16'hFFFF, 8'hAA);
		queue_access(OP_WRITE, 16'h1FFF, 8'hFB);
		queue_access(OP_READ,  16'hA000, 8'h00);
		queue_access(OP_WRITE, 16'h0000, 8'h0A);
		// ram left enabled while the bank count drops to zero
		set_bank_count(3'd0);
		queue_access(OP_READ,  16'hBFFF, 8'h00);
		queue_access(OP_WRITE, 16'hB000, 8'h3C);
		queue_access(OP_WRITE, 16'h1000, 8'hFA);
		set_bank_count(3'd2);
		queue_access(OP_WRITE, 16'h0000, 8'h0A);
		queue_access(OP_READ,  16'hB000, 8'h00);

		// random phases, one per bank count setting
		foreach (bank_counts[p]) begin
			set_bank_count(3'(bank_counts[p]));
			phase_goal = active_items + 190;
			while (active_items < phase_goal) begin
				idle_on = ($urandom_range(0, 3) != 0);
				repeat ($urandom_range(20, 60)) begin
					pick = $urandom_range(0, 99);
					op   = OP_WRITE;
					data = 8'($urandom);
					case ($urandom_range(0, 2))
						0: off = 13'($urandom_range(0, 15));
						1: off = 13'h1FF0 | 13'($urandom_range(0, 15));
						default: off = 13'($urandom);
					endcase
					if (pick < 8) begin
						addr = {3'(RGN_RAM_ENABLE), 13'($urandom)};
						if ($urandom_range(0, 9) < 7) begin
							data[3:0] = RAM_KEY;
						end
					end else if (pick < 16) begin
						addr = {3'(RGN_ROM_LOW), 13'($urandom)};
					end else if (pick < 24) begin
						addr = {3'(RGN_BANK_HIGH), 13'($urandom)};
					end else if (pick < 30) begin
						addr = {3'(RGN_MODE), 13'($urandom)};
					end else if (pick < 55) begin
						addr = {3'(RGN_RAM_WINDOW), off};
					end else if (pick < 85) begin
						op   = OP_READ;
						addr = {3'(RGN_RAM_WINDOW), off};
					end else if (pick < 92) begin
						op   = OP_READ;
						addr = 16'($urandom);
					end else begin
						op   = opcode_t'($urandom_range(0, 1));
						addr = 16'($urandom);
					end
					queue_access(op, addr, data);
				end
				do @(posedge clk);
				while (pending_reqs.size() != 0);
				// sometimes hold off until every response is back
				if ($urandom_range(0, 2) == 0) begin
					wait_quiet();
				end
			end
		end

		wait_quiet();
		repeat (10) @(posedge clk);
		$display("covered %0d requests, %0d responses checked", active_items,
			rsp_checked);
		$display("%0d ram reads returned stored bytes, bank counts 0 to 4 applied", ram_hits);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
